[rtl/nced_pkg.sv]
// Shared constants for the nearest-cache delta encoder.
// No dependencies; imported by every module of the block and by its checker.
package nced_pkg;

  // Result code width and its byte-padded stream width.
  localparam int unsigned CODE_BITS    = 22;
  localparam int unsigned M_TDATA_BITS = ((CODE_BITS + 7) / 8) * 8;

  // Copy codes reserve this many index slots, whatever the list depth.
  localparam int unsigned INDEX_SLOTS  = 8;
  // Shift that multiplies the delta/sign term by 2*INDEX_SLOTS.
  localparam int unsigned SLOT_SHIFT   = $clog2(2 * INDEX_SLOTS);

endpackage

[rtl/nced_match.sv]
// Per-entry copy-code lanes and the minimum-select tree over them.
// Depends on nced_pkg.
module nced_match #(
  parameter int unsigned LIST_DEPTH  = 8,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned IDX_BITS    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  parameter int unsigned FILL_BITS   = $clog2(LIST_DEPTH + 1),
  parameter int unsigned CCODE_BITS  = SAMPLE_BITS + 6
) (
  input  logic [SAMPLE_BITS-1:0]                 sample_i,
  input  logic [LIST_DEPTH-1:0][SAMPLE_BITS-1:0] entries_i,
  input  logic [FILL_BITS-1:0]                   fill_i,
  output logic                                   best_valid_o,
  output logic [CCODE_BITS-1:0]                  best_code_o,
  output logic [IDX_BITS-1:0]                    best_pos_o
);
  import nced_pkg::*;

  localparam int unsigned LEAVES = 1 << IDX_BITS;
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  typedef struct packed {
    logic                  valid;
    logic [CCODE_BITS-1:0] code;
    logic [IDX_BITS-1:0]   pos;
  } cand_t;

  logic [LIST_DEPTH-1:0][CCODE_BITS-1:0] lane_code;
  cand_t                                 node [NODES];

  for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_lane
    logic signed [SAMPLE_BITS:0] diff;
    logic [SAMPLE_BITS:0]        mag_full;
    logic                        sgn;

    assign diff     = $signed({sample_i[SAMPLE_BITS-1], sample_i})
                    - $signed({entries_i[j][SAMPLE_BITS-1], entries_i[j]});
    assign mag_full = diff[SAMPLE_BITS] ? (-diff) : diff;
    // Sign set when the sample lies above the entry.
    assign sgn      = !diff[SAMPLE_BITS] && (diff != '0);
    assign lane_code[j] = (CCODE_BITS'({mag_full[SAMPLE_BITS-1:0], sgn}) << SLOT_SHIFT)
                        + CCODE_BITS'(2 * j + 1);
  end

  // Heap-ordered tree: leaves at LEAVES-1 upward, the lower index wins a tie.
  always_comb begin
    for (int k = 0; k < LEAVES; k++) begin
      if (k < LIST_DEPTH) begin
        node[LEAVES-1+k].valid = (FILL_BITS'(k) < fill_i);
        node[LEAVES-1+k].code  = lane_code[k];
      end else begin
        node[LEAVES-1+k].valid = 1'b0;
        node[LEAVES-1+k].code  = '0;
      end
      node[LEAVES-1+k].pos = IDX_BITS'(k);
    end
    for (int k = LEAVES - 2; k >= 0; k--) begin
      if (node[2*k+1].valid &&
          (!node[2*k+2].valid || (node[2*k+1].code <= node[2*k+2].code))) begin
        node[k] = node[2*k+1];
      end else begin
        node[k] = node[2*k+2];
      end
    end
  end

  assign best_valid_o = node[0].valid;
  assign best_code_o  = node[0].code;
  assign best_pos_o   = node[0].pos;

endmodule

[rtl/nced_list.sv]
// Most-recent-first list of earlier samples and its fill count.
// Depends on nced_pkg.
module nced_list #(
  parameter int unsigned LIST_DEPTH  = 8,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned IDX_BITS    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  parameter int unsigned FILL_BITS   = $clog2(LIST_DEPTH + 1)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   update_i,
  input  logic                                   start_i,
  input  logic [SAMPLE_BITS-1:0]                 sample_i,
  input  logic                                   copy_i,
  input  logic [IDX_BITS-1:0]                    pos_i,
  output logic [LIST_DEPTH-1:0][SAMPLE_BITS-1:0] entries_o,
  output logic [FILL_BITS-1:0]                   fill_o
);
  import nced_pkg::*;

  logic [LIST_DEPTH-1:0][SAMPLE_BITS-1:0] entries_q, entries_d;
  logic [FILL_BITS-1:0]                   fill_q, fill_d, fill_eff;

  // Start of block empties the list ahead of this sample.
  assign fill_eff = start_i ? '0 : fill_q;
  assign fill_d   = (fill_eff == FILL_BITS'(LIST_DEPTH)) ? fill_eff
                                                         : fill_eff + FILL_BITS'(1);

  // Move the matched entry up, then push the sample in front.
  assign entries_d[0] = sample_i;
  for (genvar i = 1; i < LIST_DEPTH; i++) begin : g_shift
    if (i == 1) begin : g_second
      assign entries_d[i] = copy_i ? entries_q[pos_i] : entries_q[0];
    end else begin : g_rest
      assign entries_d[i] = (copy_i && (IDX_BITS'(i - 1) <= pos_i)) ? entries_q[i-2]
                                                                   : entries_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (update_i) begin
      entries_q <= entries_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (update_i) begin
      fill_q <= fill_d;
    end
  end

  assign entries_o = entries_q;
  assign fill_o    = fill_eff;

endmodule

[rtl/nearest_cache_delta_encoder_unit.sv]
// A request taken into the input register is encoded into the result register when unstalled.
// Throughput: one sample per cycle unless the output stalls; the list compare, minimum
// tree and list update form a single pass between the input register and the result register.
// Stalls on the result side back up through the input register to s_axis_tready_o.
// Reset clears both valid flags and the fill count; list entries are not reset.
// Depends on nced_pkg, nced_list, nced_match.
module nearest_cache_delta_encoder_unit #(
  parameter int unsigned LIST_DEPTH  = 8,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata_i,  // sample
  input  logic                                  s_axis_tuser_i,  // start_of_block
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [nced_pkg::M_TDATA_BITS-1:0]     m_axis_tdata_o,  // code
  output logic                                  m_axis_tuser_o   // is_copy
);
  import nced_pkg::*;

  localparam int unsigned IDX_BITS   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned FILL_BITS  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CCODE_BITS = SAMPLE_BITS + 6;

  logic                                   in_valid_q, in_valid_d;
  logic [SAMPLE_BITS-1:0]                 sample_q;
  logic                                   start_q;
  logic                                   out_valid_q, out_valid_d;
  logic [CODE_BITS-1:0]                   code_q, code_d;
  logic                                   copy_q;

  logic                                   s_accept, advance, fire;
  logic [LIST_DEPTH-1:0][SAMPLE_BITS-1:0] entries;
  logic [FILL_BITS-1:0]                   fill;
  logic                                   best_valid;
  logic [CCODE_BITS-1:0]                  best_code;
  logic [IDX_BITS-1:0]                    best_pos;
  logic [SAMPLE_BITS:0]                   literal;
  logic                                   copy_d;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  nced_list #(
    .LIST_DEPTH  (LIST_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_BITS    (IDX_BITS),
    .FILL_BITS   (FILL_BITS)
  ) u_list (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .update_i  (fire),
    .start_i   (start_q),
    .sample_i  (sample_q),
    .copy_i    (copy_d),
    .pos_i     (best_pos),
    .entries_o (entries),
    .fill_o    (fill)
  );

  nced_match #(
    .LIST_DEPTH  (LIST_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_BITS    (IDX_BITS),
    .FILL_BITS   (FILL_BITS),
    .CCODE_BITS  (CCODE_BITS)
  ) u_match (
    .sample_i     (sample_q),
    .entries_i    (entries),
    .fill_i       (fill),
    .best_valid_o (best_valid),
    .best_code_o  (best_code),
    .best_pos_o   (best_pos)
  );

  // Literal and copy codes differ in parity; a negative literal always wins.
  assign literal = {sample_q, 1'b0};
  assign copy_d  = best_valid && !literal[SAMPLE_BITS]
                && (best_code < CCODE_BITS'(literal));
  assign code_d  = copy_d ? CODE_BITS'(best_code) : CODE_BITS'($signed(literal));

  assign in_valid_d  = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      sample_q <= s_axis_tdata_i[SAMPLE_BITS-1:0];
      start_q  <= s_axis_tuser_i;
    end
    if (fire) begin
      code_q <= code_d;
      copy_q <= copy_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_BITS - CODE_BITS){1'b0}}, code_q};
  assign m_axis_tuser_o  = copy_q;

endmodule

[rtl/nced_checker.sv]
// Port-level checks for the nearest-cache delta encoder, bound to its top level.
// Depends on nced_pkg and nearest_cache_delta_encoder_unit.
module nced_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [nced_pkg::M_TDATA_BITS-1:0] m_axis_tdata_o,
  input logic                              m_axis_tuser_o
);
  import nced_pkg::*;

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // Copy codes are odd, literals even.
  a_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[0] == m_axis_tuser_o))
    else $error("code parity disagrees with copy flag");

  // A draining output lets a new request in during the same cycle.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output drains");

endmodule

bind nearest_cache_delta_encoder_unit nced_checker u_nced_checker (.*);

[verif/tb_nearest_cache_delta_encoder_unit.sv]
// Self-checking bench for nearest_cache_delta_encoder_unit: directed and random samples
// against a move-to-front list predictor, with bursty sender and stalling receiver.
// Depends on nced_pkg and the encoder RTL.
`timescale 1ns / 100ps

module tb_nearest_cache_delta_encoder_unit;

  localparam int unsigned LIST_DEPTH  = 8;
  localparam int unsigned SAMPLE_BITS = 16;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_BURSTY
  } rx_mode_e;

  typedef struct packed {
    logic [nced_pkg::CODE_BITS-1:0] code;
    logic                           is_copy;
  } code_result_t;

  logic                              clk_i           = 1'b0;
  logic                              rst_ni          = 1'b0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  logic [SAMPLE_BITS-1:0]            s_axis_tdata_i  = '0;  // sample
  logic                              s_axis_tuser_i  = 1'b0; // start_of_block
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  logic [nced_pkg::M_TDATA_BITS-1:0] m_axis_tdata_o;         // code
  logic                              m_axis_tuser_o;         // is_copy

  // Predictor state: most recent sample first.
  logic signed [SAMPLE_BITS-1:0] recent_q [LIST_DEPTH];
  int unsigned                   recent_fill = 0;

  code_result_t expected_codes[$];
  int           n_errors   = 0;
  rx_mode_e     rx_mode    = RX_ALWAYS;
  bit           tx_bursty  = 1'b0;
  int           burst_left = 0;
  int           rx_hold    = 0;

  nearest_cache_delta_encoder_unit #(
    .LIST_DEPTH  (LIST_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #10 clk_i = ~clk_i;

  // Pick the cheapest of the literal and every valid list entry, then update the list.
  function automatic code_result_t encode_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                                                 input logic sob);
    code_result_t                  res;
    int                            best;
    int                            cand;
    int                            mag;
    int unsigned                   best_pos;
    bit                            copy;
    logic signed [SAMPLE_BITS-1:0] held;
    best     = 2 * int'(smp);
    best_pos = 0;
    copy     = 1'b0;
    if (sob) begin
      recent_fill = 0;
    end
    for (int unsigned j = 0; j < recent_fill; j++) begin
      mag = int'(smp) - int'(recent_q[j]);
      if (mag < 0) begin
        mag = -mag;
      end
      cand = 2 * (int'(nced_pkg::INDEX_SLOTS) * (2 * mag + ((smp > recent_q[j]) ? 1 : 0))
             + int'(j)) + 1;
      if (cand < best) begin
        best     = cand;
        best_pos = j;
        copy     = 1'b1;
      end
    end
    if (copy) begin
      held = recent_q[best_pos];
      for (int unsigned i = best_pos; i > 0; i--) begin
        recent_q[i] = recent_q[i-1];
      end
      recent_q[0] = held;
    end
    if (recent_fill < LIST_DEPTH) begin
      recent_fill++;
    end
    for (int unsigned i = recent_fill - 1; i > 0; i--) begin
      recent_q[i] = recent_q[i-1];
    end
    recent_q[0] = smp;
    res.code    = best[nced_pkg::CODE_BITS-1:0];
    res.is_copy = copy;
    return res;
  endfunction

  // Offer one request, hold it until taken, then maybe leave a gap.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic sob);
    int gap;
    gap = 0;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= smp;
    s_axis_tuser_i  <= sob;
    @(posedge clk_i);
    while (s_axis_tready_o !== 1'b1) begin
      @(posedge clk_i);
    end
    expected_codes.insert(expected_codes.size(), encode_sample(smp, sob));
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    case (rx_mode)
      RX_ALWAYS: m_axis_tready_i <= 1'b1;
      RX_RANDOM: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      default: begin
        // Mostly ready, with the odd long stall.
        if (rx_hold > 0) begin
          rx_hold--;
          m_axis_tready_i <= 1'b0;
        end else if ($urandom_range(0, 23) == 0) begin
          rx_hold = $urandom_range(3, 20);
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    code_result_t want;
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected result code %h is_copy %b", $time,
                 m_axis_tdata_o[nced_pkg::CODE_BITS-1:0], m_axis_tuser_o);
        n_errors++;
      end else begin
        want = expected_codes.pop_front();
        if (m_axis_tdata_o[nced_pkg::CODE_BITS-1:0] !== want.code) begin
          $display("%0t: code expected %h actual %h", $time, want.code,
                   m_axis_tdata_o[nced_pkg::CODE_BITS-1:0]);
          n_errors++;
        end
        if (m_axis_tuser_o !== want.is_copy) begin
          $display("%0t: is_copy expected %b actual %b", $time, want.is_copy,
                   m_axis_tuser_o);
          n_errors++;
        end
      end
    end
  end

  // Empty list always yields a literal, including both sample extremes.
  task automatic test_empty_list;
    send_sample(16'h0000, 1'b1);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b1);
  endtask

  // Far entries lose to the literal; an exact match further down wins.
  task automatic test_extremes;
    send_sample(16'h7fff, 1'b0);
    send_sample(16'hffff, 1'b0);
    send_sample(16'h7fff, 1'b0);
  endtask

  // Exact copy, sample above and below an entry, small value staying literal.
  task automatic test_copy_sign;
    send_sample(16'd1000, 1'b1);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1003, 1'b0);
    send_sample(16'd998, 1'b0);
    send_sample(16'd5, 1'b0);
  endtask

  // Overfill the list, copy from the deepest slot, then miss on a dropped value.
  task automatic test_list_wrap;
    send_sample(16'd100, 1'b1);
    for (int k = 2; k <= 10; k++) begin
      send_sample(16'(k * 100), 1'b0);
    end
    send_sample(16'd301, 1'b0);
    send_sample(16'd199, 1'b0);
  endtask

  task automatic test_random(input int n_items, input rx_mode_e mode, input bit bursty);
    int                     pick;
    logic [SAMPLE_BITS-1:0] smp;
    logic                   sob;
    rx_mode   = mode;
    tx_bursty = bursty;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      sob  = ($urandom_range(0, 39) == 0);
      if (pick < 55 && recent_fill > 0) begin
        // Land near a live entry so copies are common.
        smp = recent_q[$urandom_range(0, recent_fill - 1)]
              + SAMPLE_BITS'($signed($urandom_range(0, 16)) - 8);
      end else if (pick < 80) begin
        smp = SAMPLE_BITS'($urandom());
      end else if (pick < 95) begin
        smp = SAMPLE_BITS'($urandom_range(0, 4000));
      end else begin
        smp = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      end
      send_sample(smp, sob);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    rx_mode   = RX_RANDOM;
    tx_bursty = 1'b1;
    test_empty_list();
    test_extremes();
    test_copy_sign();
    test_list_wrap();
    test_random(240, RX_ALWAYS, 1'b0);
    test_random(240, RX_RANDOM, 1'b1);
    test_random(230, RX_BURSTY, 1'b0);
    test_random(240, RX_BURSTY, 1'b1);
    s_axis_tvalid_i <= 1'b0;
    while (expected_codes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (n_errors == 0 && expected_codes.size() == 0) begin
      $display("nearest_cache_delta_encoder_unit test passed");
    end else begin
      $display("nearest_cache_delta_encoder_unit test failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("nearest_cache_delta_encoder_unit test failed");
    $finish;
  end

endmodule
